// ===== rtl/core/dq_pkg.sv =====
package dq_pkg;

    localparam int DATA_W   = 32;
    localparam int ACTION_W = 3;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic [ACTION_W-1:0]      action_t;
    typedef logic [COUNT_W-1:0]       count_t;
    typedef logic [STATUS_W-1:0]      status_t;

    localparam action_t ACT_PUSH_FRONT = 3'd0;
    localparam action_t ACT_PUSH_REAR  = 3'd1;
    localparam action_t ACT_POP_FRONT  = 3'd2;
    localparam action_t ACT_POP_REAR   = 3'd3;
    localparam action_t ACT_REPORT     = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ===== rtl/core/dq_mem.sv =====
module dq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  dq_pkg::mem_ctl_t  ctl,
    input  logic [AW-1:0]     wr_addr,
    input  dq_pkg::word_t     wr_data,
    input  logic [AW-1:0]     rd_addr,
    output dq_pkg::word_t     rd_data
);
    import dq_pkg::*;

    word_t mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/dq_ctrl.sv =====
module dq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dq_pkg::action_t   action,
    input  dq_pkg::word_t     value,
    output logic              busy,
    output logic              done,
    output dq_pkg::word_t     taken_value,
    output dq_pkg::word_t     front_value,
    output dq_pkg::word_t     rear_value,
    output logic [CW-1:0]     held,
    output dq_pkg::status_t   status,
    output dq_pkg::mem_ctl_t  mem_ctl,
    output logic [AW-1:0]     wr_addr,
    output dq_pkg::word_t     wr_data,
    output logic [AW-1:0]     rd_addr,
    input  dq_pkg::word_t     rd_data
);
    import dq_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] wrap_up(input logic [AW-1:0] i);
        wrap_up = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_down(input logic [AW-1:0] i);
        wrap_down = (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    logic [AW-1:0] front_idx_reg, front_idx_next;
    logic [AW-1:0] rear_idx_reg, rear_idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg;
    logic          done_reg;
    word_t         front_val_reg, front_val_next;
    word_t         rear_val_reg, rear_val_next;
    word_t         pend_front_reg, pend_front_next;
    word_t         pend_rear_reg, pend_rear_next;
    logic          load_front_reg, load_front_next;
    logic          load_rear_reg, load_rear_next;
    word_t         taken_reg, taken_next;
    status_t       status_reg, status_next;
    logic          accept;
    logic          empty;
    logic          full;
    logic [AW-1:0] new_rear_idx;

    assign accept       = start && !busy_reg;
    assign empty        = (cnt_reg == '0);
    assign full         = (cnt_reg == FULL_CNT);
    assign new_rear_idx = wrap_down(rear_idx_reg);

    always_comb
    begin
        front_idx_next  = front_idx_reg;
        rear_idx_next   = rear_idx_reg;
        cnt_next        = cnt_reg;
        pend_front_next = front_val_reg;
        pend_rear_next  = rear_val_reg;
        load_front_next = 1'b0;
        load_rear_next  = 1'b0;
        taken_next      = '0;
        status_next     = ST_OK;
        mem_ctl         = '0;
        wr_addr         = front_idx_reg;
        wr_data         = value;
        rd_addr         = front_idx_reg;
        case (action)
            ACT_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    front_idx_next  = wrap_down(front_idx_reg);
                    wr_addr         = front_idx_next;
                    mem_ctl.wr_en   = accept;
                    cnt_next        = cnt_reg + 1'b1;
                    pend_front_next = value;
                    if (empty)
                    begin
                        pend_rear_next = value;
                    end
                end
            end
            ACT_PUSH_REAR:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_addr        = rear_idx_reg;
                    mem_ctl.wr_en  = accept;
                    rear_idx_next  = wrap_up(rear_idx_reg);
                    cnt_next       = cnt_reg + 1'b1;
                    pend_rear_next = value;
                    if (empty)
                    begin
                        pend_front_next = value;
                    end
                end
            end
            ACT_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    taken_next     = front_val_reg;
                    front_idx_next = wrap_up(front_idx_reg);
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        pend_front_next = '0;
                        pend_rear_next  = '0;
                    end
                    else if (cnt_reg == CW'(2))
                    begin
                        pend_front_next = rear_val_reg;
                    end
                    else
                    begin
                        rd_addr         = front_idx_next;
                        mem_ctl.rd_en   = accept;
                        load_front_next = 1'b1;
                    end
                end
            end
            ACT_POP_REAR:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    taken_next    = rear_val_reg;
                    rear_idx_next = new_rear_idx;
                    cnt_next      = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        pend_front_next = '0;
                        pend_rear_next  = '0;
                    end
                    else if (cnt_reg == CW'(2))
                    begin
                        pend_rear_next = front_val_reg;
                    end
                    else
                    begin
                        rd_addr        = wrap_down(new_rear_idx);
                        mem_ctl.rd_en  = accept;
                        load_rear_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_idx_reg <= '0;
            rear_idx_reg  <= '0;
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            front_val_reg <= '0;
            rear_val_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg;
            busy_reg <= accept;
            if (accept)
            begin
                front_idx_reg <= front_idx_next;
                rear_idx_reg  <= rear_idx_next;
                cnt_reg       <= cnt_next;
            end
            if (busy_reg)
            begin
                front_val_reg <= front_val_next;
                rear_val_reg  <= rear_val_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_front_reg <= pend_front_next;
            pend_rear_reg  <= pend_rear_next;
            load_front_reg <= load_front_next;
            load_rear_reg  <= load_rear_next;
            taken_reg      <= taken_next;
            status_reg     <= status_next;
        end
    end

    assign front_val_next = load_front_reg ? rd_data : pend_front_reg;
    assign rear_val_next  = load_rear_reg ? rd_data : pend_rear_reg;

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign taken_value = taken_reg;
    assign front_value = front_val_reg;
    assign rear_value  = rear_val_reg;
    assign held        = cnt_reg;
    assign status      = status_reg;

    a_one_cycle_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> !busy_reg && done_reg)
        else $error("work phase longer than one cycle");

    a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done_reg)
        else $error("accepted request without result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("count above depth");

    a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && cnt_reg == '0 |-> front_val_reg == '0 && rear_val_reg == '0)
        else $error("empty queue shows nonzero ends");

    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("read and write issued together");

endmodule

// ===== rtl/core/double_ended_queue_unit.sv =====
// channel  | handshake            | signals
// ---------+----------------------+------------------------------------------
// request  | start high, busy low | action, value
// result   | done, one cycle      | taken_value, front_value, rear_value,
//          |                      | count, status
//
// In the accept cycle a request updates pointers and count and issues any
// entry read; the next cycle loads the read word or the new end value into
// the front or rear register. done rises in the cycle after that, and busy is
// low again in the done cycle, so the next request can be taken then.
// This order is set by the registered read of the single-read-port memory.
// Reset clears pointers, count and end registers; entries are not cleared.
// The receiver cannot stall; each result is shown for one cycle only.
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dq_pkg::action_t  action,
    input  dq_pkg::word_t    value,
    output logic             done,
    output dq_pkg::word_t    taken_value,
    output dq_pkg::word_t    front_value,
    output dq_pkg::word_t    rear_value,
    output dq_pkg::count_t   count,
    output dq_pkg::status_t  status
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] wr_addr;
    word_t         wr_data;
    logic [AW-1:0] rd_addr;
    word_t         rd_data;
    logic [CW-1:0] held;
    logic [XW-1:0] held_ext;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .value       (value),
        .busy        (busy),
        .done        (done),
        .taken_value (taken_value),
        .front_value (front_value),
        .rear_value  (rear_value),
        .held        (held),
        .status      (status),
        .mem_ctl     (mem_ctl),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    dq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign held_ext = XW'(held);
    assign count    = held_ext[COUNT_W-1:0];

endmodule

// ===== tb/sv/double_ended_queue_unit_tb.sv =====
`timescale 1ns / 100ps

module double_ended_queue_unit_tb;

    import dq_pkg::*;

    localparam int DQ_DEPTH    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 1000;

    typedef struct {
        action_t act;
        word_t   val;
        bit      wait_idle;
    } request_t;

    typedef struct {
        word_t   taken;
        word_t   front;
        word_t   rear;
        count_t  held;
        status_t st;
    } deque_out_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    action_t action = ACT_REPORT;
    word_t   value = '0;
    logic    busy;
    logic    done;
    word_t   taken_value;
    word_t   front_value;
    word_t   rear_value;
    count_t  count;
    status_t status;

    request_t   request_q[$];
    deque_out_t deque_results_q[$];

    word_t slots[DQ_DEPTH];
    int    head_idx;
    int    tail_idx;
    int    held_cnt;

    int gap_left;
    int quiet_left;
    int error_cnt;
    int cycle_cnt;

    double_ended_queue_unit #(
        .DEPTH(DQ_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .value(value),
        .done(done),
        .taken_value(taken_value),
        .front_value(front_value),
        .rear_value(rear_value),
        .count(count),
        .status(status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic deque_out_t deque_apply(input action_t act, input word_t val);
        deque_out_t r;
        r.taken = '0;
        r.front = '0;
        r.rear  = '0;
        r.st    = ST_OK;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_REAR:
            begin
                if (held_cnt >= DQ_DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else if (act == ACT_PUSH_FRONT)
                begin
                    head_idx = (head_idx == 0) ? DQ_DEPTH - 1 : head_idx - 1;
                    slots[head_idx] = val;
                    held_cnt++;
                end
                else
                begin
                    slots[tail_idx] = val;
                    tail_idx = (tail_idx + 1) % DQ_DEPTH;
                    held_cnt++;
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR:
            begin
                if (held_cnt == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else if (act == ACT_POP_FRONT)
                begin
                    r.taken = slots[head_idx];
                    head_idx = (head_idx + 1) % DQ_DEPTH;
                    held_cnt--;
                end
                else
                begin
                    tail_idx = (tail_idx == 0) ? DQ_DEPTH - 1 : tail_idx - 1;
                    r.taken = slots[tail_idx];
                    held_cnt--;
                end
            end
            default:
            begin
            end
        endcase
        if (held_cnt != 0)
        begin
            r.front = slots[head_idx];
            r.rear  = slots[(tail_idx == 0) ? DQ_DEPTH - 1 : tail_idx - 1];
        end
        r.held = count_t'(held_cnt);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 149) == 0)
        begin
            quiet_left = $urandom_range(30, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Accept on start && !busy; hold start while busy.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            action   <= ACT_REPORT;
            value    <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                deque_results_q.push_back(deque_apply(action, value));
            if (start && busy)
            begin
            end
            else if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (request_q.size() != 0 &&
                     !(request_q[0].wait_idle && deque_results_q.size() != 0))
            begin
                start    <= 1'b1;
                action   <= request_q[0].act;
                value    <= request_q[0].val;
                gap_left <= pick_gap();
                void'(request_q.pop_front());
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (deque_results_q.size() == 0)
            begin
                $error("unexpected result: taken_value %0d, count %0d", taken_value, count);
                error_cnt++;
            end
            else
            begin
                deque_out_t e;
                e = deque_results_q.pop_front();
                if (taken_value !== e.taken)
                begin
                    $error("taken_value: expected %0d, got %0d", e.taken, taken_value);
                    error_cnt++;
                end
                if (front_value !== e.front)
                begin
                    $error("front_value: expected %0d, got %0d", e.front, front_value);
                    error_cnt++;
                end
                if (rear_value !== e.rear)
                begin
                    $error("rear_value: expected %0d, got %0d", e.rear, rear_value);
                    error_cnt++;
                end
                if (count !== e.held)
                begin
                    $error("count: expected %0d, got %0d", e.held, count);
                    error_cnt++;
                end
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    error_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_request(input action_t act, input word_t val, input bit wait_idle = 1'b0);
        request_t q;
        q.act       = act;
        q.val       = val;
        q.wait_idle = wait_idle;
        request_q.push_back(q);
    endtask

    function automatic word_t rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return {1'b1, {(DATA_W-1){1'b0}}};
        else if (r < 6)
            return {1'b0, {(DATA_W-1){1'b1}}};
        else if (r < 8)
            return '1;
        else if (r < 10)
            return '0;
        return word_t'($urandom);
    endfunction

    function automatic action_t rand_push();
        return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
    endfunction

    function automatic action_t rand_pop();
        return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
    endfunction

    // Report plus the unused codes above it.
    function automatic action_t rand_other();
        return ACT_REPORT + action_t'($urandom_range(0, 3));
    endfunction

    initial
    begin
        int made;
        int mode;
        int len;
        int r;
        action_t act;

        head_idx   = 0;
        tail_idx   = 0;
        held_cnt   = 0;
        quiet_left = 0;
        error_cnt  = 0;
        cycle_cnt  = 0;
        foreach (slots[i])
            slots[i] = '0;

        add_request(ACT_POP_FRONT, word_t'($urandom));
        add_request(ACT_POP_REAR, word_t'($urandom));
        add_request(ACT_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
        add_request(ACT_PUSH_REAR, {1'b0, {(DATA_W-1){1'b1}}});
        add_request(ACT_REPORT, '1);
        add_request(ACT_REPORT + action_t'(1), '1);
        add_request(ACT_REPORT + action_t'(2), '0);
        add_request(ACT_REPORT + action_t'(3), '1);
        add_request(ACT_POP_FRONT, '0);
        add_request(ACT_POP_REAR, '0);
        for (int i = 0; i < DQ_DEPTH; i++)
            add_request((i % 2) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, rand_word());
        add_request(ACT_PUSH_FRONT, '1);
        add_request(ACT_PUSH_REAR, '0);

        // Bursts biased to fill, drain or churn the deque.
        made = 0;
        while (made < RANDOM_REQS)
        begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(4, 40);
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: act = (r < 80) ? rand_push() : (r < 95) ? rand_pop() : rand_other();
                    1: act = (r < 80) ? rand_pop() : (r < 95) ? rand_push() : rand_other();
                    default: act = (r < 42) ? rand_push() : (r < 84) ? rand_pop() : rand_other();
                endcase
                add_request(act, rand_word(), (made == 0) || ($urandom_range(0, 149) == 0));
                made++;
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_q.size() != 0 || start || deque_results_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_cnt == 0 && deque_results_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dq_pkg.sv
rtl/core/dq_mem.sv
rtl/core/dq_ctrl.sv
rtl/core/double_ended_queue_unit.sv
tb/sv/double_ended_queue_unit_tb.sv
